FILE: rtl/core/sdpd_pkg.sv
package sdpd_pkg;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_ROWLO,
    PH_OFFLO,
    PH_LEN,
    PH_LENLO,
    PH_LIT,
    PH_COPY
  } sdpd_phase_e;

  localparam logic [7:0]  CMD_ROW_COPY   = 8'd248;
  localparam logic [7:0]  CMD_ROW_SET    = 8'd240;
  localparam logic [7:0]  CMD_LONG_SKIP  = 8'd224;
  localparam logic [7:0]  LEN_LONG       = 8'd240;
  localparam logic [7:0]  MASK_LOW3      = 8'h07;
  localparam logic [7:0]  MASK_LOW4      = 8'h0f;
  localparam logic [11:0] ROW_WIDTH_RST  = 12'd1024;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } sdpd_in_t;

  typedef struct packed {
    logic [22:0] write_address;
    logic [7:0]  write_data;
    logic        out_of_range;
  } sdpd_out_t;

  typedef struct packed {
    logic      valid;
    sdpd_out_t item;
  } sdpd_res_t;

endpackage

FILE: rtl/core/sdpd_parser.sv
module sdpd_parser #(
  parameter int MAX_ROW_PIXELS = 2048,
  parameter int FRAME_BYTES    = 8388608
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sdpd_pkg::sdpd_in_t item_i,
  input  logic [11:0]       row_width_i,
  output sdpd_pkg::sdpd_res_t res_o
);

  localparam int PosW = $clog2(FRAME_BYTES + 1);
  localparam int SumW = ((PosW > 24) ? PosW : 24) + 1;
  localparam logic [SumW-1:0] FrameLim = SumW'(FRAME_BYTES);
  localparam logic [12:0] MaxWidth = 13'(MAX_ROW_PIXELS);

  sdpd_pkg::sdpd_phase_e phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [10:0]     offset_q, offset_d;
  logic [12:0]     rem_q, rem_d;
  logic [3:0]      held_q, held_d;
  logic            mode_q, mode_d;
  logic [12:0]     cidx_q, cidx_d;

  logic [7:0]      b;
  logic            last;
  logic [11:0]     eff_w;
  logic [12:0]     row_bytes;
  logic [10:0]     row_num;
  logic [23:0]     row_prod;
  logic [SumW-1:0] row_s, skip_s, inc_s, copy_s, addr_s;
  logic [PosW-1:0] row_pos, skip_pos, inc_pos;
  logic            oor;

  assign b    = item_i.byte_value;
  assign last = item_i.last_byte;

  assign eff_w     = ({1'b0, row_width_i} > MaxWidth) ? MaxWidth[11:0] : row_width_i;
  assign row_bytes = {eff_w, 1'b0};
  assign row_num   = {held_q[2:0], b};
  assign row_prod  = 24'(row_num) * 24'(row_bytes);

  assign row_s  = SumW'(row_prod);
  assign skip_s = SumW'(pos_q) + SumW'(offset_q);
  assign inc_s  = SumW'(pos_q) + SumW'(1);
  assign copy_s = SumW'(pos_q) + SumW'(cidx_q);

  assign row_pos  = PosW'((row_s  >= FrameLim) ? FrameLim : row_s);
  assign skip_pos = PosW'((skip_s >= FrameLim) ? FrameLim : skip_s);
  assign inc_pos  = PosW'((inc_s  >= FrameLim) ? FrameLim : inc_s);

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      sdpd_pkg::PH_CMD: begin
        if (b >= sdpd_pkg::CMD_ROW_SET) begin
          phase_d = sdpd_pkg::PH_ROWLO;
        end else if (b >= sdpd_pkg::CMD_LONG_SKIP) begin
          phase_d = sdpd_pkg::PH_OFFLO;
        end else begin
          phase_d = sdpd_pkg::PH_LEN;
        end
      end
      sdpd_pkg::PH_ROWLO: begin
        phase_d = (mode_q && (row_bytes != '0)) ? sdpd_pkg::PH_COPY : sdpd_pkg::PH_CMD;
      end
      sdpd_pkg::PH_OFFLO: phase_d = sdpd_pkg::PH_LEN;
      sdpd_pkg::PH_LEN: begin
        if (b >= sdpd_pkg::LEN_LONG) begin
          phase_d = sdpd_pkg::PH_LENLO;
        end else begin
          phase_d = (b != '0) ? sdpd_pkg::PH_LIT : sdpd_pkg::PH_CMD;
        end
      end
      sdpd_pkg::PH_LENLO: begin
        phase_d = ({held_q, b} != '0) ? sdpd_pkg::PH_LIT : sdpd_pkg::PH_CMD;
      end
      sdpd_pkg::PH_LIT, sdpd_pkg::PH_COPY: begin
        if (rem_q == 13'd1) begin
          phase_d = sdpd_pkg::PH_CMD;
        end
      end
      default: phase_d = sdpd_pkg::PH_CMD;
    endcase
    if (last) begin
      phase_d = sdpd_pkg::PH_CMD;
    end
  end

  // position, counters and held bits
  always_comb begin
    pos_d    = pos_q;
    offset_d = offset_q;
    rem_d    = rem_q;
    held_d   = held_q;
    mode_d   = mode_q;
    cidx_d   = cidx_q;
    case (phase_q)
      sdpd_pkg::PH_CMD: begin
        if (b >= sdpd_pkg::CMD_ROW_SET) begin
          held_d = 4'(b & sdpd_pkg::MASK_LOW3);
          mode_d = (b >= sdpd_pkg::CMD_ROW_COPY);
        end else begin
          offset_d = 11'(b & sdpd_pkg::MASK_LOW3);
        end
      end
      sdpd_pkg::PH_ROWLO: begin
        pos_d = row_pos;
        if (mode_q && (row_bytes != '0)) begin
          rem_d  = row_bytes;
          cidx_d = '0;
        end
      end
      sdpd_pkg::PH_OFFLO: offset_d = {offset_q[2:0], b};
      sdpd_pkg::PH_LEN: begin
        if (b >= sdpd_pkg::LEN_LONG) begin
          held_d = 4'(b & sdpd_pkg::MASK_LOW4);
        end else begin
          rem_d = 13'(b);
          pos_d = skip_pos;
        end
      end
      sdpd_pkg::PH_LENLO: begin
        rem_d = 13'({held_q, b});
        pos_d = skip_pos;
      end
      sdpd_pkg::PH_LIT: begin
        pos_d = inc_pos;
        rem_d = rem_q - 13'd1;
      end
      sdpd_pkg::PH_COPY: begin
        cidx_d = cidx_q + 13'd1;
        rem_d  = rem_q - 13'd1;
      end
      default: begin
      end
    endcase
    if (last) begin
      pos_d    = '0;
      offset_d = '0;
      rem_d    = '0;
      held_d   = '0;
      mode_d   = 1'b0;
      cidx_d   = '0;
    end
  end

  // byte write
  always_comb begin
    addr_s = (phase_q == sdpd_pkg::PH_COPY) ? copy_s : SumW'(pos_q);
    oor    = (addr_s >= FrameLim);
    res_o.valid = step_i &&
                  ((phase_q == sdpd_pkg::PH_LIT) || (phase_q == sdpd_pkg::PH_COPY));
    res_o.item.write_address = oor ? 23'd0 : addr_s[22:0];
    res_o.item.write_data    = b;
    res_o.item.out_of_range  = oor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sdpd_pkg::PH_CMD;
      pos_q    <= '0;
      offset_q <= '0;
      rem_q    <= '0;
      held_q   <= '0;
      mode_q   <= 1'b0;
      cidx_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      offset_q <= offset_d;
      rem_q    <= rem_d;
      held_q   <= held_d;
      mode_q   <= mode_d;
      cidx_q   <= cidx_d;
    end
  end

  a_lit_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == sdpd_pkg::PH_LIT) || (phase_q == sdpd_pkg::PH_COPY)) |-> (rem_q != '0))
    else $error("write phase with no bytes left");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SumW'(pos_q) <= FrameLim))
    else $error("position past frame limit");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last) |=> ((phase_q == sdpd_pkg::PH_CMD) && (pos_q == '0) && (rem_q == '0)))
    else $error("last byte did not reset parser");

  a_oor_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.out_of_range) |-> (res_o.item.write_address == '0))
    else $error("flagged write carries an address");

endmodule

FILE: rtl/core/screen_delta_patch_decoder_core.sv
// an accepted byte is held in the input register; its write is registered in the output register when the parser steps
// throughput: one input byte per cycle while the output is not stalled, at most one write per byte
// the parser and the row multiply sit between the input and output registers
// reset: parser expects a command, position and counters zero, row width 1024
// reset is asynchronous and active low; no clearing pass is needed
module screen_delta_patch_decoder_core #(
  parameter int MAX_ROW_PIXELS = 2048,
  parameter int FRAME_BYTES    = 8388608
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdpd_pkg::sdpd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdpd_pkg::sdpd_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_wdata_i
);

  logic               in_valid_q, in_valid_d;
  sdpd_pkg::sdpd_in_t in_data_q;
  logic               out_valid_q, out_valid_d;
  sdpd_pkg::sdpd_out_t out_data_q;
  logic [11:0]        row_width_q;
  logic               out_free, step, accept;
  sdpd_pkg::sdpd_res_t res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res.valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  sdpd_parser #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_data_q),
    .row_width_i(row_width_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_width_q <= sdpd_pkg::ROW_WIDTH_RST;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
    if (step && res.valid) begin
      out_data_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: bench/patch_write_checker.sv
module patch_write_checker
  import sdpd_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = 2048,
  parameter int FRAME_BYTES    = 8388608
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  sdpd_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  sdpd_out_t   out_data_i,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          writes_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  sdpd_phase_e phase     = PH_CMD;
  logic [24:0] position  = '0;
  logic [10:0] offset    = '0;
  logic [12:0] remaining = '0;
  logic [3:0]  high_bits = '0;
  logic        copy_mode = 1'b0;
  logic [12:0] copy_idx  = '0;
  logic [11:0] row_width = ROW_WIDTH_RST;

  sdpd_out_t expected_writes[$];
  int mismatches = 0;
  int pending    = 0;

  assign fail_count_o     = mismatches;
  assign writes_pending_o = pending;

  function automatic logic [24:0] saturate(input logic [25:0] pos);
    return (pos >= FRAME_BYTES) ? 25'(FRAME_BYTES) : pos[24:0];
  endfunction

  function automatic logic [12:0] row_span();
    logic [11:0] w;
    w = (row_width > MAX_ROW_PIXELS) ? 12'(MAX_ROW_PIXELS) : row_width;
    return {w, 1'b0};
  endfunction

  task automatic clear_parser();
    phase     = PH_CMD;
    position  = '0;
    offset    = '0;
    remaining = '0;
    high_bits = '0;
    copy_mode = 1'b0;
    copy_idx  = '0;
  endtask

  task automatic expect_write(input logic [25:0] addr, input logic [7:0] data);
    sdpd_out_t w;
    w.write_data    = data;
    w.out_of_range  = (addr >= FRAME_BYTES);
    w.write_address = w.out_of_range ? '0 : addr[22:0];
    expected_writes.push_back(w);
  endtask

  task automatic begin_literal();
    position = saturate(26'(position) + 26'(offset));
    phase    = (remaining != 0) ? PH_LIT : PH_CMD;
  endtask

  task automatic decode_byte(input sdpd_in_t item);
    logic [7:0]  b;
    logic [10:0] row;
    logic [12:0] span;
    logic [25:0] prod;
    b = item.byte_value;
    case (phase)
      PH_CMD: begin
        if (b >= CMD_ROW_SET) begin
          high_bits = 4'(b & MASK_LOW3);
          copy_mode = (b >= CMD_ROW_COPY);
          phase     = PH_ROWLO;
        end else begin
          offset = 11'(b & MASK_LOW3);
          phase  = (b >= CMD_LONG_SKIP) ? PH_OFFLO : PH_LEN;
        end
      end
      PH_ROWLO: begin
        row      = {high_bits[2:0], b};
        span     = row_span();
        prod     = 26'(row) * 26'(span);
        position = saturate(prod);
        if (copy_mode && span != 0) begin
          remaining = span;
          copy_idx  = '0;
          phase     = PH_COPY;
        end else begin
          phase = PH_CMD;
        end
      end
      PH_OFFLO: begin
        offset = {offset[2:0], b};
        phase  = PH_LEN;
      end
      PH_LEN: begin
        if (b >= LEN_LONG) begin
          high_bits = 4'(b & MASK_LOW4);
          phase     = PH_LENLO;
        end else begin
          remaining = 13'(b);
          begin_literal();
        end
      end
      PH_LENLO: begin
        remaining = {1'b0, high_bits, b};
        begin_literal();
      end
      PH_LIT: begin
        expect_write(26'(position), b);
        position  = saturate(26'(position) + 26'd1);
        remaining = remaining - 13'd1;
        if (remaining == 0) phase = PH_CMD;
      end
      PH_COPY: begin
        expect_write(26'(position) + 26'(copy_idx), b);
        copy_idx  = copy_idx + 13'd1;
        remaining = remaining - 13'd1;
        if (remaining == 0) phase = PH_CMD;
      end
      default: phase = PH_CMD;
    endcase
    if (item.last_byte) clear_parser();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sdpd_out_t want;
    if (!rst_ni) begin
      clear_parser();
      row_width = ROW_WIDTH_RST;
      expected_writes.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected write transfer: address %0h data %0h out_of_range %0b",
                 out_data_i.write_address, out_data_i.write_data, out_data_i.out_of_range);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          if (out_data_i.write_address !== want.write_address) begin
            $error("write_address: expected %0h, got %0h",
                   want.write_address, out_data_i.write_address);
            mismatches++;
          end
          if (out_data_i.write_data !== want.write_data) begin
            $error("write_data: expected %0h, got %0h", want.write_data, out_data_i.write_data);
            mismatches++;
          end
          if (out_data_i.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b",
                   want.out_of_range, out_data_i.out_of_range);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) row_width = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
    end
    pending = expected_writes.size();
  end

endmodule

FILE: bench/screen_delta_patch_decoder_core_tb.sv
module screen_delta_patch_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdpd_pkg::*;

  localparam int MAX_ROW_PIXELS = 2048;
  localparam int FRAME_BYTES    = 8388608;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int PHASE_BYTES    = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  sdpd_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  sdpd_out_t   out_data;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  int          fail_count;
  int          writes_pending;

  int cycle_count  = 0;
  int phase_bytes  = 0;
  int row_span_now = 2 * 1024;
  int send_level   = 1;
  int stall_level  = 1;
  int stall_left   = 0;

  screen_delta_patch_decoder_core #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .FRAME_BYTES   (FRAME_BYTES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  patch_write_checker #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .FRAME_BYTES   (FRAME_BYTES)
  ) write_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .writes_pending_o(writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("screen_delta_patch_decoder_core_tb: done, errors");
      $finish;
    end
  end

  // write-side back pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (stall_level != 0 && $urandom_range(99) < 15 * stall_level)
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if ($urandom_range(299) == 0) stall_level = $urandom_range(2);
  end

  function automatic int pick_gap(input int level);
    int r;
    r = $urandom_range(99);
    if (level == 0 || r < ((level == 1) ? 80 : 40)) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = pick_gap(send_level);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_data.byte_value = value;
    in_data.last_byte  = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    phase_bytes++;
  endtask

  // last_at: index of the byte that carries the last flag, -1 for none
  task automatic send_bytes(input logic [7:0] seq[$], input int last_at);
    for (int i = 0; i < seq.size() && (last_at < 0 || i <= last_at); i++)
      send_byte(seq[i], i == last_at);
  endtask

  task automatic configure_row_width(input logic [11:0] width);
    in_valid = 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = width;
    @(negedge clk);
    cfg_we       = 1'b0;
    row_span_now = 2 * ((width > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : int'(width));
  endtask

  task automatic send_random_command();
    logic [7:0] seq[$];
    int kind;
    int r;
    int count;
    int hi;
    int lo;
    int cut;
    if ($urandom_range(9) == 0) send_level = $urandom_range(2);
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_byte(8'($urandom), 1'($urandom_range(1)));
      return;
    end
    if (kind < 22 && row_span_now <= 64) begin
      seq.push_back(8'($urandom_range(248, 255)));
      seq.push_back(8'($urandom));
      count = row_span_now;
    end else if (kind < 32) begin
      seq.push_back(8'($urandom_range(240, 247)));
      seq.push_back(8'($urandom));
      count = 0;
    end else begin
      if (kind < 60) begin
        seq.push_back(8'($urandom_range(0, 223)));
      end else begin
        seq.push_back(8'($urandom_range(224, 239)));
        seq.push_back(8'($urandom));
      end
      r = $urandom_range(99);
      if (r < 75) begin
        count = $urandom_range(0, 6);
        seq.push_back(8'(count));
      end else if (r < 88) begin
        count = $urandom_range(0, 239);
        seq.push_back(8'(count));
      end else begin
        hi = ($urandom_range(19) == 0) ? 1 : 0;
        lo = (hi != 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        seq.push_back(8'(240 + hi));
        seq.push_back(8'(lo));
        count = hi * 256 + lo;
      end
    end
    repeat (count) seq.push_back(8'($urandom));
    r = $urandom_range(99);
    if (r < 10) cut = $urandom_range(seq.size() - 1);
    else if (r < 15) cut = seq.size() - 1;
    else cut = -1;
    send_bytes(seq, cut);
  endtask

  initial begin
    logic [11:0] widths[5];
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset width: literals, long skip, row set, long length, zero length, cut commands
    send_level = 0;
    send_bytes('{8'h00, 8'h02, 8'h00, 8'hFF}, -1);
    send_bytes('{8'hE7, 8'hFF, 8'h01, 8'hA5}, -1);
    send_bytes('{8'hF5, 8'h12}, -1);
    send_bytes('{8'h03, 8'hF0, 8'h02, 8'h5A, 8'hC3}, -1);
    send_bytes('{8'hDF, 8'h00}, -1);
    send_bytes('{8'h01, 8'h03, 8'h11, 8'h22}, 3);
    send_bytes('{8'hE0}, 0);
    send_bytes('{8'h00, 8'h01, 8'h33}, -1);

    // short rows: copy, copy cut by last byte, row set then skip
    configure_row_width(12'd2);
    send_level = 2;
    send_bytes('{8'hF9, 8'h01, 8'h00, 8'hFF, 8'h80, 8'h7F}, -1);
    send_bytes('{8'hF8, 8'h00, 8'h12, 8'h34}, 3);
    send_bytes('{8'hF6, 8'h03, 8'h05, 8'h01, 8'hEE}, -1);

    // zero width: row copy gives no writes
    configure_row_width(12'd0);
    send_bytes('{8'hF8, 8'h10, 8'h00, 8'h01, 8'h44}, -1);

    // widest rows: saturation past the frame end, then a copy of the last row cut short
    configure_row_width(12'hFFF);
    send_level = 1;
    send_bytes('{8'hF7, 8'hFF, 8'hE7, 8'hFF, 8'h00, 8'hE7, 8'hFF, 8'h00,
                 8'hE7, 8'hFF, 8'h00, 8'h00, 8'h02, 8'h9C, 8'h63}, -1);
    send_bytes('{8'hFF, 8'hFF}, -1);
    repeat (24) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
    send_bytes('{8'h00, 8'h01, 8'h21}, 2);

    widths[0] = 12'd1;
    widths[1] = 12'($urandom_range(3, 12));
    widths[2] = 12'd2048;
    widths[3] = 12'($urandom_range(0, 32));
    widths[4] = 12'd2;
    foreach (widths[p]) begin
      configure_row_width(widths[p]);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_command();
    end

    in_valid = 1'b0;
    while (writes_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("screen_delta_patch_decoder_core_tb: done, clean");
    end else begin
      $display("screen_delta_patch_decoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule
